// ----- rtl/u8u16_pkg.sv -----
// types, constants and helpers shared by the utf-8 to utf-16 stream blocks
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned AccW  = 21;
  localparam int unsigned QDepth = 4;
  localparam int unsigned CntW   = 3;

  localparam logic [ByteW-1:0] BomB0 = 8'hEF;
  localparam logic [ByteW-1:0] BomB1 = 8'hBB;
  localparam logic [ByteW-1:0] BomB2 = 8'hBF;
  localparam logic [1:0]       ContTag = 2'b10;
  localparam logic [AccW-1:0]  BmpMax  = 21'h00FFFF;
  localparam logic [AccW-1:0]  SuppBase = 21'h010000;
  localparam logic [UnitW-1:0] HiSurr  = 16'hD800;
  localparam logic [UnitW-1:0] LoSurr  = 16'hDC00;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LEAD = 6'b000010,
    S_ACC  = 6'b000100,
    S_CODE = 6'b001000,
    S_LOW  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  // request from the sequencer to the output stage
  typedef struct packed {
    logic             produce;
    logic             flush;
    logic             done;
    logic [UnitW-1:0] unit;
  } out_req_t;

  // sequence length from the lead byte, zero when it cannot start one
  function automatic logic [CntW-1:0] seq_len(input logic [ByteW-1:0] c);
    logic [CntW-1:0] len;
    len = 3'd0;
    priority if (c[7] == 1'b0) begin
      len = 3'd1;
    end else if (c[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (c[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

endpackage

// ----- rtl/u8u16_out.sv -----
// one-unit hold stage and output register that marks the last unit before each flush
`timescale 1ns / 1ps

module u8u16_out (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  u8u16_pkg::out_req_t    req_i,
  output logic                   room_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [15:0]            m_axis_tdata,  // code_unit
  output logic                   m_axis_tlast,  // last_of_run
  output logic [0:0]             m_axis_tuser   // stream_done
);

  logic                          hold_v_q, hold_v_d;
  logic [u8u16_pkg::UnitW-1:0]   hold_q, hold_d;
  logic                          out_v_q, out_v_d;
  logic [u8u16_pkg::UnitW-1:0]   out_unit_q, out_unit_d;
  logic                          out_last_q, out_last_d;
  logic                          out_done_q, out_done_d;
  logic                          slot_free;
  logic                          push;

  assign slot_free = !out_v_q || m_axis_tready;
  assign room_o    = !hold_v_q || slot_free;
  assign push      = hold_v_q && (req_i.produce || req_i.flush) && room_o;

  always_comb begin
    hold_v_d   = hold_v_q;
    hold_d     = hold_q;
    out_v_d    = out_v_q && !m_axis_tready;
    out_unit_d = out_unit_q;
    out_last_d = out_last_q;
    out_done_d = out_done_q;
    if (push) begin
      out_v_d    = 1'b1;
      out_unit_d = hold_q;
      out_last_d = req_i.flush;
      out_done_d = req_i.flush && req_i.done;
    end
    if (room_o && req_i.produce) begin
      hold_v_d = 1'b1;
      hold_d   = req_i.unit;
    end else if (room_o && req_i.flush) begin
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    out_unit_q <= out_unit_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_unit_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_done_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_v_q || m_axis_tready))
    else $error("output register overwritten while waiting");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.flush && !req_i.produce && room_o) |=> !hold_v_q)
    else $error("hold stage not emptied by flush");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (!out_done_q || out_last_q))
    else $error("stream done without last of run");

endmodule

// ----- rtl/utf8_to_utf16_stream.sv -----
// top level of the utf-8 byte stream to utf-16 code unit transcoder
`timescale 1ns / 1ps

// Takes one UTF-8 byte per request and gives UTF-16 code units, one per request
// on the output, with a surrogate pair above 0xFFFF. A leading EF BB BF at stream
// start is dropped; a byte that cannot start a sequence, or the lead of a
// sequence broken by a bad continuation or by the end of text, is given raw and
// the later bytes are scanned again. One byte is taken at a time: s_axis_tready
// is high only while the sequencer is idle. Each byte goes through an accept in
// S_IDLE, a scan of each lead in S_LEAD (a raw lead goes out there), a fold of
// each continuation byte into the code point by the shared 6-bit shift-accumulate
// unit in S_ACC, S_CODE for each decoded code point and S_LOW for the low half of
// a surrogate pair, a scan that finds the queue empty or the sequence unfinished,
// and S_FIN to finish; any step that gives output waits while m_axis_tready holds
// the output back.
module utf8_to_utf16_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_value
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // code_unit
  output logic        m_axis_tlast,   // last_of_run
  output logic [0:0]  m_axis_tuser    // stream_done
);

  u8u16_pkg::state_e             state_q, state_d;
  logic [u8u16_pkg::ByteW-1:0]   q_q [u8u16_pkg::QDepth];
  logic [u8u16_pkg::ByteW-1:0]   q_d [u8u16_pkg::QDepth];
  logic [u8u16_pkg::CntW-1:0]    n_q, n_d;
  logic                          last_q, last_d;
  logic                          start_q, start_d;
  logic                          bom_q, bom_d;
  logic [1:0]                    rem_q, rem_d;
  logic [u8u16_pkg::AccW-1:0]    acc_q, acc_d;
  logic [u8u16_pkg::CntW-1:0]    len;
  logic                          bad;
  logic                          short_seq;
  logic                          accept;
  logic                          room;
  logic [u8u16_pkg::AccW-1:0]    supp;
  logic [u8u16_pkg::UnitW-1:0]   hi_unit;
  logic [u8u16_pkg::UnitW-1:0]   lo_unit;
  u8u16_pkg::out_req_t           req;

  assign s_axis_tready = (state_q == u8u16_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign len = u8u16_pkg::seq_len(q_q[0]);
  assign bad = ((len > 3'd1) && (n_q > 3'd1) && (q_q[1][7:6] != u8u16_pkg::ContTag)) ||
               ((len > 3'd2) && (n_q > 3'd2) && (q_q[2][7:6] != u8u16_pkg::ContTag)) ||
               ((len > 3'd3) && (n_q > 3'd3) && (q_q[3][7:6] != u8u16_pkg::ContTag));
  assign short_seq = (n_q < len);

  assign supp    = acc_q - u8u16_pkg::SuppBase;
  assign hi_unit = u8u16_pkg::HiSurr + 16'(supp[20:10]);
  assign lo_unit = u8u16_pkg::LoSurr + 16'(supp[9:0]);

  always_comb begin
    state_d = state_q;
    q_d     = q_q;
    n_d     = n_q;
    last_d  = last_q;
    start_d = start_q;
    bom_d   = bom_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    req     = '0;
    req.done = last_q;

    unique case (state_q)
      u8u16_pkg::S_IDLE: begin
        if (accept) begin
          q_d[n_q[1:0]] = s_axis_tdata;
          n_d     = n_q + 3'd1;
          last_d  = s_axis_tlast;
          state_d = u8u16_pkg::S_LEAD;
        end
      end
      u8u16_pkg::S_LEAD: begin
        if (n_q == 3'd0) begin
          state_d = u8u16_pkg::S_FIN;
        end else if ((len == 3'd0) || bad || (short_seq && last_q)) begin
          req.produce = 1'b1;
          req.unit    = 16'(q_q[0]);
          if (room) begin
            for (int i = 0; i < 3; i++) q_d[i] = q_q[i+1];
            n_d     = n_q - 3'd1;
            start_d = 1'b0;
          end
        end else if (short_seq) begin
          state_d = u8u16_pkg::S_FIN;
        end else begin
          unique case (len)
            3'd2:    acc_d = 21'(q_q[0][4:0]);
            3'd3:    acc_d = 21'(q_q[0][3:0]);
            3'd4:    acc_d = 21'(q_q[0][2:0]);
            default: acc_d = 21'(q_q[0]);
          endcase
          bom_d = start_q && (len == 3'd3) && (q_q[0] == u8u16_pkg::BomB0) &&
                  (q_q[1] == u8u16_pkg::BomB1) && (q_q[2] == u8u16_pkg::BomB2);
          rem_d = 2'(len - 3'd1);
          for (int i = 0; i < 3; i++) q_d[i] = q_q[i+1];
          n_d     = n_q - 3'd1;
          state_d = (len == 3'd1) ? u8u16_pkg::S_CODE : u8u16_pkg::S_ACC;
        end
      end
      u8u16_pkg::S_ACC: begin
        acc_d = {acc_q[14:0], q_q[0][5:0]};
        for (int i = 0; i < 3; i++) q_d[i] = q_q[i+1];
        n_d   = n_q - 3'd1;
        rem_d = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          state_d = u8u16_pkg::S_CODE;
        end
      end
      u8u16_pkg::S_CODE: begin
        if (bom_q) begin
          start_d = 1'b0;
          state_d = u8u16_pkg::S_LEAD;
        end else if (acc_q <= u8u16_pkg::BmpMax) begin
          req.produce = 1'b1;
          req.unit    = acc_q[15:0];
          if (room) begin
            start_d = 1'b0;
            state_d = u8u16_pkg::S_LEAD;
          end
        end else begin
          req.produce = 1'b1;
          req.unit    = hi_unit;
          if (room) begin
            start_d = 1'b0;
            state_d = u8u16_pkg::S_LOW;
          end
        end
      end
      u8u16_pkg::S_LOW: begin
        req.produce = 1'b1;
        req.unit    = lo_unit;
        if (room) begin
          state_d = u8u16_pkg::S_LEAD;
        end
      end
      u8u16_pkg::S_FIN: begin
        req.flush = 1'b1;
        if (room) begin
          if (last_q) begin
            n_d     = 3'd0;
            start_d = 1'b1;
          end
          state_d = u8u16_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = u8u16_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= u8u16_pkg::S_IDLE;
      n_q     <= 3'd0;
      start_q <= 1'b1;
      last_q  <= 1'b0;
      bom_q   <= 1'b0;
      rem_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      start_q <= start_d;
      last_q  <= last_d;
      bom_q   <= bom_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    acc_q <= acc_d;
  end

  u8u16_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .room_o        (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= 3'd4)
    else $error("byte queue overfilled");

  a_accept_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == u8u16_pkg::S_LEAD))
    else $error("accepted byte not scanned");

  a_acc_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == u8u16_pkg::S_ACC) |-> ((rem_q != 2'd0) && (n_q != 3'd0)))
    else $error("continuation fold without a queued byte");

  a_idle_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == u8u16_pkg::S_IDLE) |-> (n_q <= 3'd3))
    else $error("idle with a full queue");

endmodule
